// ===== design/hmrv_pkg.sv =====
// Shared types, constants and character-class helpers for the height-map row validator.
`timescale 1ns / 1ps

package hmrv_pkg;

  // Number of hex digits in a colour suffix.
  localparam int HEX_DIGITS = 6;

  // Width of the hex digit counter; it counts up to HEX_DIGITS - 1.
  localparam int HEX_CNT_W = (HEX_DIGITS > 1) ? $clog2(HEX_DIGITS) : 1;

  // Count value, one wider than the counter, at which a colour is complete.
  localparam logic [HEX_CNT_W:0] HEX_LIMIT = (HEX_CNT_W + 1)'(HEX_DIGITS);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;

  // Position in the row grammar.
  typedef enum logic [3:0] {
    PH_START  = 4'd0,   // row start, nothing seen
    PH_LEAD   = 4'd1,   // leading whitespace only
    PH_SIGN   = 4'd2,   // sign taken, digit required
    PH_DIGITS = 4'd3,   // inside an integer
    PH_AFTNUM = 4'd4,   // whitespace after an integer
    PH_COMMA  = 4'd5,   // comma taken, whitespace skipped
    PH_ZERO   = 4'd6,   // '0' after comma, 'x' required
    PH_HEX    = 4'd7,   // taking hex digits
    PH_FULL   = 4'd8,   // all hex digits taken
    PH_SEP    = 4'd9,   // whitespace after a colour
    PH_FAIL   = 4'd10   // row already invalid
  } phase_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_sign(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || ((c >= CH_LA) && (c <= CH_LF)) || ((c >= CH_UA) && (c <= CH_UF));
  endfunction

endpackage

// ===== design/hmrv_parser.sv =====
// Row grammar state machine: phase and hex digit count, advanced one character per step.
`timescale 1ns / 1ps

module hmrv_parser
  import hmrv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] ch,
  output logic       row_ok
);

  phase_t                 phase;
  phase_t                 phase_next;
  logic [HEX_CNT_W-1:0]   hex_count;
  logic [HEX_CNT_W-1:0]   hex_count_next;
  logic [HEX_CNT_W:0]     hex_inc;

  assign hex_inc = {1'b0, hex_count} + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_START;
      hex_count <= '0;
    end else if (step) begin
      phase     <= phase_next;
      hex_count <= hex_count_next;
    end
  end

  // Next state. A NUL closes the row and returns to the row start.
  always_comb begin
    phase_next     = PH_FAIL;
    hex_count_next = hex_count;
    if (ch == CH_NUL) begin
      phase_next     = PH_START;
      hex_count_next = '0;
    end else begin
      unique case (phase)
        PH_START, PH_LEAD, PH_SEP: begin
          if (is_space(ch))      phase_next = (phase == PH_START) ? PH_LEAD : phase;
          else if (is_sign(ch))  phase_next = PH_SIGN;
          else if (is_digit(ch)) phase_next = PH_DIGITS;
        end
        PH_SIGN: begin
          if (is_digit(ch)) phase_next = PH_DIGITS;
        end
        PH_DIGITS: begin
          if (is_digit(ch))           phase_next = PH_DIGITS;
          else if (is_space(ch))      phase_next = PH_AFTNUM;
          else if (ch == CH_COMMA)    phase_next = PH_COMMA;
        end
        PH_AFTNUM: begin
          if (is_space(ch))           phase_next = PH_AFTNUM;
          else if (is_digit(ch))      phase_next = PH_DIGITS;
          else if (is_sign(ch))       phase_next = PH_SIGN;
          else if (ch == CH_COMMA)    phase_next = PH_COMMA;
        end
        PH_COMMA: begin
          if (is_space(ch))           phase_next = PH_COMMA;
          else if (ch == CH_ZERO)     phase_next = PH_ZERO;
        end
        PH_ZERO: begin
          if (ch == CH_X) begin
            phase_next     = PH_HEX;
            hex_count_next = '0;
          end
        end
        PH_HEX: begin
          if (is_hex(ch)) begin
            if (hex_inc >= HEX_LIMIT) begin
              phase_next     = PH_FULL;
              hex_count_next = '0;
            end else begin
              phase_next     = PH_HEX;
              hex_count_next = hex_inc[HEX_CNT_W-1:0];
            end
          end
        end
        PH_FULL: begin
          if (is_space(ch)) phase_next = PH_SEP;
        end
        default: begin
          phase_next = PH_FAIL;
        end
      endcase
    end
  end

  // Whether a row ending in the current phase is well formed.
  always_comb begin
    unique case (phase)
      PH_START, PH_DIGITS, PH_AFTNUM, PH_COMMA, PH_FULL, PH_SEP: row_ok = 1'b1;
      default:                                                  row_ok = 1'b0;
    endcase
  end

endmodule

// ===== design/height_map_row_validator_top.sv =====
// Top level of the height-map row validator: input register, parser and result register.
`timescale 1ns / 1ps

// Usage
// The character channel (char_valid, char_stall, ch) carries one row character
// per request. A row is whitespace-separated signed decimal integers, each
// optionally followed by a colour suffix of a comma, optional whitespace and
// "0x" with six hex digits. A NUL character ends the row.
// The result channel (res_valid, res_stall, row_valid) carries one request per
// row, issued for the NUL: row_valid is 1 when the row was well formed.
// Other characters produce no result.
// A NUL passes through the input register and then the result register before
// its result shows on res_valid; a stalled result ahead of it can hold it back.
// Throughput: one character per cycle while char_stall is low. The parser state
// is registered, so back-to-back characters wait only on a stalled result.
// When the receiver stalls, the result stays held in the output register and
// characters keep flowing; only a second NUL reaching the input register
// while the first result is still held raises char_stall.
// Reset (rst, synchronous, active high) empties both registers and returns the
// parser to the start of a row.

module height_map_row_validator_top
  import hmrv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_stall,
  input  logic [7:0] ch,
  output logic       res_valid,
  input  logic       res_stall,
  output logic       row_valid
);

  logic       s1_vld;
  logic [7:0] s1_ch;
  logic       s1_nul;
  logic       s1_adv;
  logic       row_ok;

  assign s1_nul = (s1_ch == CH_NUL);

  // A held character moves on unless it is a NUL and the result register is
  // still full and stalled.
  assign s1_adv     = s1_vld && (!s1_nul || !res_valid || !res_stall);
  assign char_stall = s1_vld && !s1_adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (!char_stall) begin
      s1_vld <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && !char_stall) begin
      s1_ch <= ch;
    end
  end

  hmrv_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (s1_adv),
    .ch     (s1_ch),
    .row_ok (row_ok)
  );

  // Result register. The parser state is sampled before the NUL resets it.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_adv && s1_nul) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_nul) begin
      row_valid <= row_ok;
    end
  end

endmodule

// ===== design/hmrv_checker.sv =====
// Port-level assertions for the height-map row validator and their binding.
`timescale 1ns / 1ps

module hmrv_checker
  import hmrv_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       char_valid,
  input logic       char_stall,
  input logic [7:0] ch,
  input logic       res_valid,
  input logic       res_stall,
  input logic       row_valid
);

  // A stalled result holds its value.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(row_valid))
    else $error("held result changed while stalled");

  // Characters are only held back when a result is waiting on a stalled receiver.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    char_stall |-> res_valid && res_stall)
    else $error("character channel stalled with the result side free");

  // A new result must be preceded by a NUL accepted at the character port.
  a_res_from_nul: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(char_valid && !char_stall && (ch == CH_NUL), 2))
    else $error("result appeared without an accepted NUL");

endmodule

bind height_map_row_validator_top hmrv_checker u_hmrv_checker (.*);
